@@ rtl/core/mfc_pkg.sv @@
package mfc_pkg;

	localparam int SENSOR_COUNT_DEF = 4;
	localparam int SENSOR_MAX       = 16;
	localparam int SLOT_COUNT       = 11;
	localparam int QUEUE_DEPTH      = 4;

	localparam int SENSOR_W = 2;
	localparam int SLOT_W   = 4;
	localparam int COEF_W   = 24;
	localparam int FIELD_W  = 24;
	localparam int AMP_W    = 16;

	// Q7.16 slope times Q3.12 current is Q.28; baseline term is Q.8 scaled by 2^20
	localparam int PROD_W     = COEF_W + AMP_W;
	localparam int DIFF_W     = FIELD_W + 1;
	localparam int FRAC_SHIFT = 20;
	localparam int ACC_W      = 48;

	// coefficient slots within one sensor's row
	localparam int SLOT_BASE_X = 0;
	localparam int SLOT_BASE_Y = 1;
	localparam int SLOT_BASE_Z = 2;
	localparam int SLOT_X_POS  = 3;
	localparam int SLOT_X_NEG  = 4;
	localparam int SLOT_Y_POS  = 5;
	localparam int SLOT_Y_NEG  = 6;
	localparam int SLOT_ZX_POS = 7;
	localparam int SLOT_ZX_NEG = 8;
	localparam int SLOT_ZY_POS = 9;
	localparam int SLOT_ZY_NEG = 10;

	typedef enum logic {
		ACT_LOAD   = 1'b0,
		ACT_SAMPLE = 1'b1
	} action_t;

	typedef struct packed {
		action_t                    action;
		logic [SENSOR_W-1:0]        sensor_index;
		logic [SLOT_W-1:0]          coef_slot;
		logic signed [COEF_W-1:0]   coef_value;
		logic signed [FIELD_W-1:0]  field_x;
		logic signed [FIELD_W-1:0]  field_y;
		logic signed [FIELD_W-1:0]  field_z;
		logic signed [AMP_W-1:0]    amps_x_pos;
		logic signed [AMP_W-1:0]    amps_x_neg;
		logic signed [AMP_W-1:0]    amps_y_pos;
		logic signed [AMP_W-1:0]    amps_y_neg;
	} req_t;

	typedef struct packed {
		logic [SENSOR_W-1:0]        out_sensor;
		logic signed [FIELD_W-1:0]  comp_x;
		logic signed [FIELD_W-1:0]  comp_y;
		logic signed [FIELD_W-1:0]  comp_z;
		logic                       clipped;
	} rsp_t;

	// classified queue entry
	typedef struct packed {
		logic sensor_ok;
		req_t item;
	} qent_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

@@ rtl/core/mfc_front.sv @@
module mfc_front #(
	parameter int SENSOR_COUNT = mfc_pkg::SENSOR_COUNT_DEF
) (
	input  logic           req_valid,
	input  mfc_pkg::req_t  req,
	output logic           req_stall,
	input  mfc_pkg::qstat_t qstat,
	output logic           push,
	output mfc_pkg::qent_t push_ent
);

	localparam int CMP_W = $clog2(mfc_pkg::SENSOR_MAX + 1);
	localparam int SW    = mfc_pkg::SLOT_W;

	logic sensor_ok;
	logic slot_ok;
	logic keep;

	assign sensor_ok = CMP_W'(req.sensor_index) < CMP_W'(SENSOR_COUNT);
	assign slot_ok   = req.coef_slot < SW'(mfc_pkg::SLOT_COUNT);

	// loads that hit nothing are dropped here
	assign keep = (req.action == mfc_pkg::ACT_SAMPLE) || (sensor_ok && slot_ok);

	assign req_stall = qstat.full;
	assign push      = req_valid && !qstat.full && keep;

	assign push_ent.sensor_ok = sensor_ok;
	assign push_ent.item      = req;

endmodule

@@ rtl/core/mfc_queue.sv @@
module mfc_queue #(
	parameter int DEPTH = mfc_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  mfc_pkg::qent_t  push_ent,
	input  logic            pop,
	output mfc_pkg::qent_t  head,
	output mfc_pkg::qstat_t qstat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	mfc_pkg::qent_t ents [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			ents[wr_ptr_q] <= push_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head        = ents[rd_ptr_q];
	assign qstat.full  = (count_q == CNT_W'(DEPTH));
	assign qstat.empty = (count_q == '0);

endmodule

@@ rtl/core/mfc_back.sv @@
module mfc_back #(
	parameter int SENSOR_COUNT = mfc_pkg::SENSOR_COUNT_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  mfc_pkg::qstat_t qstat,
	input  mfc_pkg::qent_t  head,
	output logic            pop,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output mfc_pkg::rsp_t   rsp
);

	localparam int ROW_W  = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
	localparam int NSLOT  = mfc_pkg::SLOT_COUNT;
	localparam int CW     = mfc_pkg::COEF_W;
	localparam int FW     = mfc_pkg::FIELD_W;
	localparam int AW     = mfc_pkg::AMP_W;
	localparam int PW     = mfc_pkg::PROD_W;
	localparam int DW     = mfc_pkg::DIFF_W;
	localparam int ACCW   = mfc_pkg::ACC_W;
	localparam int SH     = mfc_pkg::FRAC_SHIFT;
	localparam int RW     = ACCW - SH;
	localparam int NPROD  = NSLOT - mfc_pkg::SLOT_X_POS;
	localparam logic [ACCW-1:0] RND = ACCW'(1) << (SH - 1);

	function automatic logic [ACCW-1:0] ext_base(input logic [DW-1:0] d);
		return {{(ACCW - DW - SH){d[DW-1]}}, d, {SH{1'b0}}};
	endfunction

	function automatic logic [ACCW-1:0] ext_prod(input logic [PW-1:0] p);
		return {{(ACCW - PW){p[PW-1]}}, p};
	endfunction

	// floor by 2^SH then clamp to the field range; top bit is the clip flag
	function automatic logic [FW:0] sat_round(input logic [ACCW-1:0] a);
		logic [RW-1:0] r;
		logic [RW-FW:0] top;
		r   = a[ACCW-1:SH];
		top = r[RW-1:FW-1];
		if (top == '0 || top == '1) begin
			return {1'b0, r[FW-1:0]};
		end else if (r[RW-1]) begin
			return {1'b1, 1'b1, {(FW - 1){1'b0}}};
		end else begin
			return {1'b1, 1'b0, {(FW - 1){1'b1}}};
		end
	endfunction

	logic en;
	logic is_wr;
	logic is_rd;
	logic [ROW_W-1:0] row;

	logic [NSLOT-1:0][CW-1:0] mem [SENSOR_COUNT];
	logic [NSLOT-1:0] vld_q [SENSOR_COUNT];

	logic v_s1, v_s2, v_s3, out_vld_q;

	logic [NSLOT-1:0][CW-1:0] rd_s1;
	logic [NSLOT-1:0] vld_s1;
	logic ok_s1;
	logic [mfc_pkg::SENSOR_W-1:0] sens_s1, sens_s2, sens_s3;
	logic signed [FW-1:0] fx_s1, fy_s1, fz_s1;
	logic signed [AW-1:0] ixp_s1, ixn_s1, iyp_s1, iyn_s1;

	logic signed [CW-1:0] coef [NSLOT];
	logic signed [DW-1:0] dx_s2, dy_s2, dz_s2;
	logic signed [PW-1:0] prod_s2 [NPROD];

	logic [ACCW-1:0] xa_s3, xb_s3, ya_s3, yb_s3, za_s3, zb_s3, zc_s3;

	logic [FW:0] sx, sy, sz;
	mfc_pkg::rsp_t rsp_q;

	assign en    = !out_vld_q || !rsp_stall;
	assign pop   = en && !qstat.empty;
	assign row   = ROW_W'(head.item.sensor_index);
	assign is_wr = pop && (head.item.action == mfc_pkg::ACT_LOAD);
	assign is_rd = pop && (head.item.action == mfc_pkg::ACT_SAMPLE);

	// coef store: one write or row read per unstalled cycle, in queue order
	always_ff @(posedge clk) begin
		if (is_wr) begin
			mem[row][head.item.coef_slot] <= head.item.coef_value;
		end
		if (is_rd) begin
			rd_s1   <= mem[row];
			vld_s1  <= vld_q[row];
			ok_s1   <= head.sensor_ok;
			sens_s1 <= head.item.sensor_index;
			fx_s1   <= head.item.field_x;
			fy_s1   <= head.item.field_y;
			fz_s1   <= head.item.field_z;
			ixp_s1  <= head.item.amps_x_pos;
			ixn_s1  <= head.item.amps_x_neg;
			iyp_s1  <= head.item.amps_y_pos;
			iyn_s1  <= head.item.amps_y_neg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SENSOR_COUNT; s++) begin
				vld_q[s] <= '0;
			end
		end else if (is_wr) begin
			vld_q[row][head.item.coef_slot] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			v_s1      <= is_rd;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			out_vld_q <= v_s3;
		end
	end

	// unwritten entries and unknown sensors read as zero
	always_comb begin
		for (int k = 0; k < NSLOT; k++) begin
			coef[k] = (ok_s1 && vld_s1[k]) ? rd_s1[k] : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sens_s2    <= sens_s1;
			dx_s2      <= DW'(fx_s1) - DW'(coef[mfc_pkg::SLOT_BASE_X]);
			dy_s2      <= DW'(fy_s1) - DW'(coef[mfc_pkg::SLOT_BASE_Y]);
			dz_s2      <= DW'(fz_s1) - DW'(coef[mfc_pkg::SLOT_BASE_Z]);
			prod_s2[0] <= coef[mfc_pkg::SLOT_X_POS]  * ixp_s1;
			prod_s2[1] <= coef[mfc_pkg::SLOT_X_NEG]  * ixn_s1;
			prod_s2[2] <= coef[mfc_pkg::SLOT_Y_POS]  * iyp_s1;
			prod_s2[3] <= coef[mfc_pkg::SLOT_Y_NEG]  * iyn_s1;
			prod_s2[4] <= coef[mfc_pkg::SLOT_ZX_POS] * ixp_s1;
			prod_s2[5] <= coef[mfc_pkg::SLOT_ZX_NEG] * ixn_s1;
			prod_s2[6] <= coef[mfc_pkg::SLOT_ZY_POS] * iyp_s1;
			prod_s2[7] <= coef[mfc_pkg::SLOT_ZY_NEG] * iyn_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sens_s3 <= sens_s2;
			xa_s3   <= ext_base(dx_s2) + ext_prod(prod_s2[0]) + RND;
			xb_s3   <= ext_prod(prod_s2[1]);
			ya_s3   <= ext_base(dy_s2) + ext_prod(prod_s2[2]) + RND;
			yb_s3   <= ext_prod(prod_s2[3]);
			za_s3   <= ext_base(dz_s2) + ext_prod(prod_s2[4]) + RND;
			zb_s3   <= ext_prod(prod_s2[5]) + ext_prod(prod_s2[6]);
			zc_s3   <= ext_prod(prod_s2[7]);
		end
	end

	assign sx = sat_round(xa_s3 + xb_s3);
	assign sy = sat_round(ya_s3 + yb_s3);
	assign sz = sat_round(za_s3 + zb_s3 + zc_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			rsp_q.out_sensor <= sens_s3;
			rsp_q.comp_x     <= sx[FW-1:0];
			rsp_q.comp_y     <= sy[FW-1:0];
			rsp_q.comp_z     <= sz[FW-1:0];
			rsp_q.clipped    <= sx[FW] | sy[FW] | sz[FW];
		end
	end

	assign rsp_valid = out_vld_q;
	assign rsp       = rsp_q;

endmodule

@@ rtl/core/magnetometer_feedthrough_compensation_unit.sv @@
// Magnetometer feedthrough compensation. Each request beat either loads one
// of eleven per-sensor coefficients (baselines X/Y/Z, two slopes each for X,
// Y, Z-from-X and Z-from-Y) or compensates one sensor sample, returning
// raw - baseline + sum(slope * coil current) per axis, rounded half up to
// Q15.8 and saturated to 24 bits with a shared clip flag. Loads give no
// response beat; loads to an unknown sensor or a slot above ten are dropped,
// and a sample for an unknown sensor passes the raw field through. One beat
// is taken per clock while the queue is not full. A sample's response is
// registered after the queue and the store read, multiply, partial sums, and
// final sum and saturate registers. A four-beat queue sits between the
// classifier and the datapath, so requests keep flowing for four beats while
// the response side is stalled; request stall is simply that queue being
// full. Coefficients live in a SENSOR_COUNT x 11 store with one valid bit
// per entry cleared by reset, so no clearing pass is needed after reset. A
// sample straight after a load to the same sensor sees the new coefficient.
module magnetometer_feedthrough_compensation_unit #(
	parameter int SENSOR_COUNT = mfc_pkg::SENSOR_COUNT_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  mfc_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output mfc_pkg::rsp_t rsp
);

	mfc_pkg::qstat_t qstat;
	mfc_pkg::qent_t  push_ent;
	mfc_pkg::qent_t  head;
	logic            push;
	logic            pop;

	// front end: accept and classify
	mfc_front #(
		.SENSOR_COUNT(SENSOR_COUNT)
	) u_front (
		.req_valid(req_valid),
		.req(req),
		.req_stall(req_stall),
		.qstat(qstat),
		.push(push),
		.push_ent(push_ent)
	);

	// decoupling queue
	mfc_queue #(
		.DEPTH(mfc_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_ent(push_ent),
		.pop(pop),
		.head(head),
		.qstat(qstat)
	);

	// back end: coefficient store, multiply-add pipeline, response register
	mfc_back #(
		.SENSOR_COUNT(SENSOR_COUNT)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.qstat(qstat),
		.head(head),
		.pop(pop),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

	localparam int SENSOR_COUNT = mfc_pkg::SENSOR_COUNT_DEF;
	localparam int NSLOT        = mfc_pkg::SLOT_COUNT;
	localparam int SW           = mfc_pkg::SENSOR_W;
	localparam int LW           = mfc_pkg::SLOT_W;
	localparam int CW           = mfc_pkg::COEF_W;
	localparam int FW           = mfc_pkg::FIELD_W;
	localparam int AW           = mfc_pkg::AMP_W;
	// cycles with neither side taking a beat before the run is called hung
	localparam int QUIET_LIMIT  = 2000;
	// a sample's response is registered after the queue and the back-end pipeline
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASE_BEATS  = 650;
	localparam longint Q28_ONE  = longint'(1) << mfc_pkg::FRAC_SHIFT;
	localparam longint Q28_HALF = Q28_ONE / 2;
	localparam longint SAT_HI   = 8388607;
	localparam longint SAT_LO   = -8388608;

	logic           clk;
	logic           arst_n;
	logic           req_valid;
	logic           req_stall;
	mfc_pkg::req_t  req;
	logic           rsp_valid;
	logic           rsp_stall = 1'b0;
	mfc_pkg::rsp_t  rsp;

	// directed row: the beat, and a hand-worked response where one is given
	typedef struct {
		mfc_pkg::req_t beat;
		bit            typed;
		mfc_pkg::rsp_t want;
	} row_t;

	// shadow of the coefficient store, kept in step with accepted load beats
	logic signed [CW-1:0] coef_shadow [SENSOR_COUNT][NSLOT];
	mfc_pkg::rsp_t        compensated_due [$];
	row_t                 script [$];
	int                   send_idle_pct;
	int                   recv_stall_pct;
	int                   mismatches;
	int                   quiet_cycles;

	magnetometer_feedthrough_compensation_unit #(
		.SENSOR_COUNT(SENSOR_COUNT)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Predicted response for one sample beat. Each axis is summed exactly in
	// Q.28 (fields and baselines shifted up by 20, slope x current products
	// as they come), rounded half up back to Q.8 and clamped to 24 bits.
	function automatic mfc_pkg::rsp_t compensate(input mfc_pkg::req_t it);
		longint        c [NSLOT];
		longint        acc [3];
		longint        r [3];
		bit            clip;
		mfc_pkg::rsp_t o;
		clip = 1'b0;
		for (int k = 0; k < NSLOT; k++) begin
			// an unknown sensor sees an all-zero row, so raw passes through
			c[k] = (it.sensor_index < SENSOR_COUNT) ?
				longint'(coef_shadow[it.sensor_index][k]) : longint'(0);
		end
		acc[0] = (longint'($signed(it.field_x)) - c[mfc_pkg::SLOT_BASE_X]) * Q28_ONE
			+ c[mfc_pkg::SLOT_X_POS] * longint'($signed(it.amps_x_pos))
			+ c[mfc_pkg::SLOT_X_NEG] * longint'($signed(it.amps_x_neg));
		acc[1] = (longint'($signed(it.field_y)) - c[mfc_pkg::SLOT_BASE_Y]) * Q28_ONE
			+ c[mfc_pkg::SLOT_Y_POS] * longint'($signed(it.amps_y_pos))
			+ c[mfc_pkg::SLOT_Y_NEG] * longint'($signed(it.amps_y_neg));
		acc[2] = (longint'($signed(it.field_z)) - c[mfc_pkg::SLOT_BASE_Z]) * Q28_ONE
			+ c[mfc_pkg::SLOT_ZX_POS] * longint'($signed(it.amps_x_pos))
			+ c[mfc_pkg::SLOT_ZX_NEG] * longint'($signed(it.amps_x_neg))
			+ c[mfc_pkg::SLOT_ZY_POS] * longint'($signed(it.amps_y_pos))
			+ c[mfc_pkg::SLOT_ZY_NEG] * longint'($signed(it.amps_y_neg));
		for (int a = 0; a < 3; a++) begin
			// arithmetic shift of a signed value floors, giving round half up
			r[a] = (acc[a] + Q28_HALF) >>> mfc_pkg::FRAC_SHIFT;
			if (r[a] > SAT_HI) begin
				r[a] = SAT_HI;
				clip = 1'b1;
			end else if (r[a] < SAT_LO) begin
				r[a] = SAT_LO;
				clip = 1'b1;
			end
		end
		o.out_sensor = it.sensor_index;
		o.comp_x     = r[0][FW-1:0];
		o.comp_y     = r[1][FW-1:0];
		o.comp_z     = r[2][FW-1:0];
		o.clipped    = clip;
		return o;
	endfunction

	// Random value for a signed field of width w: leaning on the two extremes
	// and on small magnitudes, otherwise the full range. Truncated by the caller.
	function automatic logic [31:0] pick(input int w);
		logic [31:0] top;
		top = (32'd1 << (w - 1)) - 32'd1;
		case ($urandom_range(7))
			0: return top;
			1: return ~top;
			2, 3: return $urandom_range(511) - 32'd256;
			default: return $urandom;
		endcase
	endfunction

	function automatic mfc_pkg::req_t load_beat(input int s, input int slot,
			input logic [CW-1:0] v);
		mfc_pkg::req_t it;
		it              = '0;
		it.action       = mfc_pkg::ACT_LOAD;
		it.sensor_index = s[SW-1:0];
		it.coef_slot    = slot[LW-1:0];
		it.coef_value   = v;
		return it;
	endfunction

	function automatic mfc_pkg::req_t sample_beat(input int s,
			input logic [FW-1:0] fx, input logic [FW-1:0] fy,
			input logic [FW-1:0] fz, input logic [AW-1:0] ixp,
			input logic [AW-1:0] ixn, input logic [AW-1:0] iyp,
			input logic [AW-1:0] iyn);
		mfc_pkg::req_t it;
		it              = '0;
		it.action       = mfc_pkg::ACT_SAMPLE;
		it.sensor_index = s[SW-1:0];
		it.field_x      = fx;
		it.field_y      = fy;
		it.field_z      = fz;
		it.amps_x_pos   = ixp;
		it.amps_x_neg   = ixn;
		it.amps_y_pos   = iyp;
		it.amps_y_neg   = iyn;
		return it;
	endfunction

	function automatic mfc_pkg::rsp_t hand_rsp(input int s,
			input logic [FW-1:0] x, input logic [FW-1:0] y,
			input logic [FW-1:0] z, input logic clip);
		mfc_pkg::rsp_t o;
		o.out_sensor = s[SW-1:0];
		o.comp_x     = x;
		o.comp_y     = y;
		o.comp_z     = z;
		o.clipped    = clip;
		return o;
	endfunction

	// Random beat: roughly a third loads spread over the whole store, the odd
	// one aimed at a slot above ten, the rest samples. Every field is random
	// on every beat, unused ones too.
	function automatic mfc_pkg::req_t random_beat();
		mfc_pkg::req_t it;
		it.action       = ($urandom_range(99) < 35) ? mfc_pkg::ACT_LOAD :
			mfc_pkg::ACT_SAMPLE;
		it.sensor_index = SW'($urandom_range(SENSOR_COUNT - 1));
		it.coef_slot    = ($urandom_range(9) == 0) ? LW'($urandom_range(15)) :
			LW'($urandom_range(NSLOT - 1));
		it.coef_value   = CW'(pick(CW));
		it.field_x      = FW'(pick(FW));
		it.field_y      = FW'(pick(FW));
		it.field_z      = FW'(pick(FW));
		it.amps_x_pos   = AW'(pick(AW));
		it.amps_x_neg   = AW'(pick(AW));
		it.amps_y_pos   = AW'(pick(AW));
		it.amps_y_neg   = AW'(pick(AW));
		return it;
	endfunction

	// Offers one request beat, entered and left at a falling edge. Idle gaps
	// drop valid for whole cycles; once raised, valid and payload hold until
	// the beat is taken. The shadow store and the expectation queue are
	// updated at the accepting edge.
	task automatic send_beat(input mfc_pkg::req_t it, input bit typed,
			input mfc_pkg::rsp_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= it;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		if (it.action == mfc_pkg::ACT_LOAD) begin
			// loads to an unknown sensor or a slot above ten are dropped
			if (it.sensor_index < SENSOR_COUNT && it.coef_slot < NSLOT)
				coef_shadow[it.sensor_index][it.coef_slot] = it.coef_value;
		end else begin
			compensated_due.push_back(typed ? want : compensate(it));
		end
		@(negedge clk);
	endtask

	task automatic check_field(input string name, input int want_v, input int got_v);
		if (want_v != got_v) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d",
				$time, name, want_v, got_v);
		end
	endtask

	// Response side stall: redrawn every falling edge from the phase's rate.
	always @(negedge clk)
		rsp_stall <= ($urandom_range(99) < recv_stall_pct);

	// Response checker and hang watchdog, both on the rising edge.
	always @(posedge clk) begin
		mfc_pkg::rsp_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (compensated_due.size() == 0) begin
					mismatches++;
					$display("%0t: response beat, expected none, actual %p",
						$time, rsp);
				end else begin
					want = compensated_due.pop_front();
					check_field("out_sensor", int'(want.out_sensor),
						int'(rsp.out_sensor));
					check_field("comp_x", int'($signed(want.comp_x)),
						int'($signed(rsp.comp_x)));
					check_field("comp_y", int'($signed(want.comp_y)),
						int'($signed(rsp.comp_y)));
					check_field("comp_z", int'($signed(want.comp_z)),
						int'($signed(rsp.comp_z)));
					check_field("clipped", int'(want.clipped), int'(rsp.clipped));
				end
			end
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no beat taken for %0d cycles", $time, QUIET_LIMIT);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		row_t row;
		arst_n         = 1'b0;
		req_valid      = 1'b0;
		req            = '0;
		mismatches     = 0;
		quiet_cycles   = 0;
		send_idle_pct  = 24;
		recv_stall_pct = 88;
		foreach (coef_shadow[s, k])
			coef_shadow[s][k] = '0;

		// straight out of reset every coefficient is zero: raw passes through
		script.push_back('{sample_beat(0, 24'h7FFFFF, 24'h800000, 24'h000123,
			16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000), 1'b1,
			hand_rsp(0, 24'h7FFFFF, 24'h800000, 24'h000123, 1'b0)});
		script.push_back('{sample_beat(3, 24'h0, 24'h0, 24'h0,
			16'h8000, 16'h8000, 16'h8000, 16'h8000), 1'b1,
			hand_rsp(3, 24'h0, 24'h0, 24'h0, 1'b0)});
		// extreme baselines against extreme fields: both ends saturate
		script.push_back('{load_beat(0, mfc_pkg::SLOT_BASE_X, 24'h800000), 1'b0, '0});
		script.push_back('{load_beat(0, mfc_pkg::SLOT_BASE_Y, 24'h7FFFFF), 1'b0, '0});
		script.push_back('{sample_beat(0, 24'h7FFFFF, 24'h800000, 24'h000005,
			16'h0, 16'h0, 16'h0, 16'h0), 1'b1,
			hand_rsp(0, 24'h7FFFFF, 24'h800000, 24'h000005, 1'b1)});
		// full slope row for sensor 1, extremes and unity gains
		script.push_back('{load_beat(1, mfc_pkg::SLOT_X_POS, 24'h7FFFFF), 1'b0, '0});
		script.push_back('{load_beat(1, mfc_pkg::SLOT_X_NEG, 24'h800000), 1'b0, '0});
		script.push_back('{load_beat(1, mfc_pkg::SLOT_Y_POS, 24'h000010), 1'b0, '0});
		script.push_back('{load_beat(1, mfc_pkg::SLOT_Y_NEG, 24'hFFFFF0), 1'b0, '0});
		script.push_back('{load_beat(1, mfc_pkg::SLOT_ZX_POS, 24'h010000), 1'b0, '0});
		script.push_back('{load_beat(1, mfc_pkg::SLOT_ZX_NEG, 24'hFF0000), 1'b0, '0});
		script.push_back('{load_beat(1, mfc_pkg::SLOT_ZY_POS, 24'h7FFFFF), 1'b0, '0});
		script.push_back('{load_beat(1, mfc_pkg::SLOT_ZY_NEG, 24'h800000), 1'b0, '0});
		script.push_back('{sample_beat(1, 24'h7FFFFF, 24'h800000, 24'h000000,
			16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000), 1'b0, '0});
		// Y products of exactly plus and minus one half LSB: half rounds up
		script.push_back('{sample_beat(1, 24'h000100, 24'h000100, 24'h0,
			16'h0, 16'h0, 16'h0, 16'h8000), 1'b0, '0});
		script.push_back('{sample_beat(1, 24'h000100, 24'hFFFF00, 24'h0,
			16'h0, 16'h0, 16'h8000, 16'h0), 1'b0, '0});
		// slots above ten are dropped, so sensor 2 still passes raw through
		script.push_back('{load_beat(2, 11, 24'h7FFFFF), 1'b0, '0});
		script.push_back('{load_beat(2, 15, 24'h800000), 1'b0, '0});
		script.push_back('{sample_beat(2, 24'h123456, 24'hEDCBA9, 24'h000001,
			16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000), 1'b1,
			hand_rsp(2, 24'h123456, 24'hEDCBA9, 24'h000001, 1'b0)});
		// one mT of Z baseline pushes the most negative Z reading over the edge
		script.push_back('{load_beat(3, mfc_pkg::SLOT_BASE_Z, 24'h000100), 1'b0, '0});
		script.push_back('{sample_beat(3, 24'h000010, 24'hFFFFF0, 24'h800000,
			16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000), 1'b1,
			hand_rsp(3, 24'h000010, 24'hFFFFF0, 24'h800000, 1'b1)});
		// load followed by a sample of the same sensor, with no other beat between
		script.push_back('{load_beat(0, mfc_pkg::SLOT_X_POS, 24'h010000), 1'b0, '0});
		script.push_back('{sample_beat(0, 24'h000000, 24'h000000, 24'h000000,
			16'h1000, 16'h0, 16'h0, 16'h0), 1'b0, '0});

		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (script[i]) begin
			row = script[i];
			send_beat(row.beat, row.typed, row.want);
		end

		// random traffic in three idling regimes: slow receiver, slow sender,
		// then both flat out
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle_pct  = 24;
					recv_stall_pct = 88;
				end
				1: begin
					send_idle_pct  = 88;
					recv_stall_pct = 24;
				end
				default: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
			endcase
			for (int n = 0; n < PHASE_BEATS; n++)
				send_beat(random_beat(), 1'b0, '0);
		end
		req_valid <= 1'b0;

		// drain outstanding responses, then allow the pipeline to settle
		while (compensated_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/mfc_pkg.sv
rtl/core/mfc_front.sv
rtl/core/mfc_queue.sv
rtl/core/mfc_back.sv
rtl/core/magnetometer_feedthrough_compensation_unit.sv
verif/tb_top.sv
